// ===== rtl/bpht_pkg.sv =====
// Shared types, codes and hash mixing functions of the pair hash table.
package bpht_pkg;

    // operation codes
    localparam logic [1:0] OP_FIND = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_PUSH = 2'd2;
    localparam logic [1:0] OP_POP  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_POP_ZERO = 2'd2;
    localparam logic [1:0] ST_MARK_OVF = 2'd3;

    // configuration register indexes
    localparam logic CFG_LOAD_LIMIT    = 1'b0;
    localparam logic CFG_CLEANUP_LIMIT = 1'b1;

    localparam logic [15:0] LEVEL_MAX  = 16'hFFFF;
    localparam logic [31:0] HASH_SEED  = 32'hDEADBEEF;
    localparam int          MIX_STEPS  = 7;
    localparam int          SLOT_EMPTY = 0;
    localparam int          SLOT_DEAD  = 1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic        created;
        logic [8:0]  entry_index;
        logic [15:0] level_now;
        logic [9:0]  removed_count;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] hash;
    } fe_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] x;
        logic [31:0] y;
    } ent_t;

    typedef struct packed {
        logic [9:0] load_limit;
        logic [9:0] cleanup_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } mix_abc_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int k);
        return (v << k) | (v >> (32 - k));
    endfunction

    // one step of the final mix: target ^= source; target -= rotl(source, k)
    function automatic mix_abc_t mix_step(input mix_abc_t s, input int step);
        mix_abc_t r;
        r = s;
        case (step)
            0: r.c = (s.c ^ s.b) - rotl32(s.b, 14);
            1: r.a = (s.a ^ s.c) - rotl32(s.c, 11);
            2: r.b = (s.b ^ s.a) - rotl32(s.a, 25);
            3: r.c = (s.c ^ s.b) - rotl32(s.b, 16);
            4: r.a = (s.a ^ s.c) - rotl32(s.c, 4);
            5: r.b = (s.b ^ s.a) - rotl32(s.a, 14);
            6: r.c = (s.c ^ s.b) - rotl32(s.b, 24);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bpht_queue.sv =====
// Small first-in first-out queue of fixed-width words.
module bpht_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int DB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DB-1:0]    wp_reg, wp_next;
    logic [DB-1:0]    rp_reg, rp_next;
    logic [DB:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (DB+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == DB'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == DB'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

endmodule

// ===== rtl/bpht_front.sv =====
// Front end: accepts items and hashes the key pair in a stalling mix pipeline.
module bpht_front (
    input  logic               clk,
    input  logic               rst_n,
    input  bpht_pkg::in_item_t item,
    input  logic               push,
    output logic               full,
    input  logic               hold,
    output bpht_pkg::fe_item_t fe_item,
    output logic               fe_push,
    input  logic               fe_full
);
    import bpht_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        mix_abc_t    abc;
    } pipe_t;

    pipe_t                  stg_reg [MIX_STEPS];
    pipe_t                  stg_next [MIX_STEPS];
    pipe_t                  stg_in [MIX_STEPS];
    logic [MIX_STEPS-1:0]   vld_reg, vld_next;
    logic                   adv;
    logic                   take;

    assign adv  = !vld_reg[MIX_STEPS-1] || !fe_full;
    assign full = !adv || hold;
    assign take = push && !full;

    assign stg_in[0] = '{op: item.operation, x: item.key_x, y: item.key_y,
                         abc: '{a: item.key_x, b: item.key_y, c: HASH_SEED}};

    for (genvar k = 0; k < MIX_STEPS; k++)
    begin : g_stage
        if (k > 0)
        begin : g_link
            assign stg_in[k] = stg_reg[k-1];
        end
        always_comb
        begin
            stg_next[k]     = stg_in[k];
            stg_next[k].abc = mix_step(stg_in[k].abc, k);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign vld_next = adv ? {vld_reg[MIX_STEPS-2:0], take} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign fe_push = vld_reg[MIX_STEPS-1] && !fe_full;
    assign fe_item = '{op: stg_reg[MIX_STEPS-1].op, x: stg_reg[MIX_STEPS-1].x,
                       y: stg_reg[MIX_STEPS-1].y, hash: stg_reg[MIX_STEPS-1].abc.c};

endmodule

// ===== rtl/bpht_back.sv =====
// Back end: probe sequencer over the slot, entry and mark memories.
module bpht_back #(
    parameter int SLOTS   = 1024,
    parameter int ENTRIES = 512,
    parameter int MARKS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bpht_pkg::cfg_t     cfg,
    input  bpht_pkg::fe_item_t mq_item,
    input  logic               mq_empty,
    output logic               mq_pop,
    input  logic               out_full,
    output logic               out_push,
    output bpht_pkg::result_t  out_res,
    output logic               init_busy
);
    import bpht_pkg::*;

    localparam int SB  = $clog2(SLOTS);
    localparam int EB  = $clog2(ENTRIES);
    localparam int VB  = $clog2(ENTRIES + 2);
    localparam int MB  = $clog2(MARKS);
    localparam int AB  = $clog2(ENTRIES + 1);
    localparam int MCB = $clog2(MARKS + 1);
    localparam int CB  = $clog2(SLOTS + 1);
    localparam int LW  = (CB + 1 > 11) ? CB + 1 : 11;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_PROBE    = 14'b00000000000100,
        S_PENT     = 14'b00000000001000,
        S_DECIDE   = 14'b00000000010000,
        S_POPMARK  = 14'b00000000100000,
        S_RMENT    = 14'b00000001000000,
        S_RMSLOT   = 14'b00000010000000,
        S_RMEND    = 14'b00000100000000,
        S_RBSLOT   = 14'b00001000000000,
        S_RBENT    = 14'b00010000000000,
        S_RBPROBE  = 14'b00100000000000,
        S_MARKDROP = 14'b01000000000000,
        S_TML      = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic [15:0]   level;
        logic [AB-1:0] pos;
    } mark_t;

    // memories
    logic [VB-1:0] slot_mem [2*SLOTS];
    ent_t          ent_mem [ENTRIES];
    mark_t         mark_mem [MARKS];

    logic          slot_we;
    logic [SB:0]   slot_waddr, slot_raddr;
    logic [VB-1:0] slot_wdata, slot_q_reg;
    logic          ent_we;
    logic [EB-1:0] ent_waddr, ent_raddr;
    ent_t          ent_wdata, ent_q_reg;
    logic          mark_we;
    logic [MB-1:0] mark_waddr, mark_raddr;
    mark_t         mark_wdata, mark_q_reg;

    // control and datapath registers
    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   kx_reg, kx_next, ky_reg, ky_next, hsh_reg, hsh_next;
    logic [SB-1:0] j_reg, j_next;
    logic [SB:0]   n_reg, n_next;
    logic          dseen_reg, dseen_next;
    logic [SB-1:0] dat_reg, dat_next;
    logic [EB-1:0] pe_reg, pe_next;
    logic [SB-1:0] spot_reg, spot_next;
    logic          reuse_reg, reuse_next;
    logic          nospot_reg, nospot_next;
    logic [15:0]   level_reg, level_next;
    logic [15:0]   toplv_reg, toplv_next;
    logic [MCB-1:0] mcnt_reg, mcnt_next;
    logic [AB-1:0] alloc_reg, alloc_next;
    logic [CB-1:0] live_reg, live_next;
    logic [CB-1:0] del_reg, del_next;
    logic          bank_reg, bank_next;
    logic          rebuild_reg, rebuild_next;
    logic [SB-1:0] idx_reg, idx_next;
    logic [AB-1:0] rme_reg, rme_next;
    logic [AB-1:0] rmend_reg, rmend_next;
    logic [VB-1:0] rbv_reg, rbv_next;
    result_t       res_reg, res_next;

    logic          adv, rm_step, rb_step;
    logic [SB-1:0] j_inc;
    logic [SB:0]   n_inc;
    logic [AB-1:0] e_inc;
    logic [MCB-1:0] mtop;
    logic [LW-1:0] lim, use_cnt;
    logic          need_mark, tbl_full;

    assign init_busy = (state_reg == S_CLEAR) && !rebuild_reg;

    always_comb
    begin
        out_res           = res_reg;
        out_res.level_now = level_reg;
    end

    assign lim = (LW'(cfg.load_limit) < LW'(SLOTS - 1)) ? LW'(cfg.load_limit)
                                                         : LW'(SLOTS - 1);
    assign use_cnt   = LW'(live_reg) + LW'(del_reg) + LW'(1);
    assign need_mark = level_reg > toplv_reg;
    assign tbl_full  = nospot_reg || (alloc_reg >= AB'(ENTRIES)) ||
                       (!reuse_reg && (use_cnt > lim));
    assign mtop      = mcnt_reg - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        kx_next      = kx_reg;
        ky_next      = ky_reg;
        hsh_next     = hsh_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        dseen_next   = dseen_reg;
        dat_next     = dat_reg;
        pe_next      = pe_reg;
        spot_next    = spot_reg;
        reuse_next   = reuse_reg;
        nospot_next  = nospot_reg;
        level_next   = level_reg;
        toplv_next   = toplv_reg;
        mcnt_next    = mcnt_reg;
        alloc_next   = alloc_reg;
        live_next    = live_reg;
        del_next     = del_reg;
        bank_next    = bank_reg;
        rebuild_next = rebuild_reg;
        idx_next     = idx_reg;
        rme_next     = rme_reg;
        rmend_next   = rmend_reg;
        rbv_next     = rbv_reg;
        res_next     = res_reg;
        slot_we      = 1'b0;
        slot_waddr   = '0;
        slot_wdata   = '0;
        slot_raddr   = '0;
        ent_we       = 1'b0;
        ent_waddr    = '0;
        ent_wdata    = '0;
        ent_raddr    = '0;
        mark_we      = 1'b0;
        mark_waddr   = '0;
        mark_wdata   = '0;
        mark_raddr   = '0;
        mq_pop       = 1'b0;
        out_push     = 1'b0;
        adv          = 1'b0;
        rm_step      = 1'b0;
        rb_step      = 1'b0;
        j_inc        = j_reg + 1'b1;
        n_inc        = n_reg + 1'b1;
        e_inc        = rme_reg + 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = {rebuild_reg ? ~bank_reg : bank_reg, idx_reg};
                slot_wdata = VB'(SLOT_EMPTY);
                if (idx_reg == SB'(SLOTS - 1))
                begin
                    idx_next = '0;
                    if (rebuild_reg)
                    begin
                        slot_raddr = {bank_reg, {SB{1'b0}}};
                        state_next = S_RBSLOT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (!mq_empty && !out_full)
                begin
                    mq_pop     = 1'b1;
                    op_next    = mq_item.op;
                    kx_next    = mq_item.x;
                    ky_next    = mq_item.y;
                    hsh_next   = mq_item.hash;
                    res_next   = '0;
                    dseen_next = 1'b0;
                    case (mq_item.op)
                        OP_FIND, OP_GET:
                        begin
                            j_next      = mq_item.hash[SB-1:0];
                            n_next      = '0;
                            dseen_next  = 1'b0;
                            nospot_next = 1'b0;
                            reuse_next  = 1'b0;
                            slot_raddr  = {bank_reg, mq_item.hash[SB-1:0]};
                            state_next  = S_PROBE;
                        end
                        OP_PUSH:
                        begin
                            if (level_reg != LEVEL_MAX)
                            begin
                                level_next = level_reg + 1'b1;
                            end
                            state_next = S_TML;
                        end
                        default:
                        begin
                            if (level_reg == '0)
                            begin
                                res_next.status = ST_POP_ZERO;
                                state_next      = S_TML;
                            end
                            else if (level_reg == toplv_reg && mcnt_reg != '0)
                            begin
                                mark_raddr = MB'(mtop);
                                state_next = S_POPMARK;
                            end
                            else
                            begin
                                level_next = level_reg - 1'b1;
                                state_next = S_TML;
                            end
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                if (slot_q_reg == VB'(SLOT_EMPTY))
                begin
                    spot_next  = dseen_reg ? dat_reg : j_reg;
                    reuse_next = dseen_reg;
                    state_next = S_DECIDE;
                end
                else if (slot_q_reg == VB'(SLOT_DEAD))
                begin
                    if (!dseen_reg)
                    begin
                        dseen_next = 1'b1;
                        dat_next   = j_reg;
                    end
                    adv = 1'b1;
                end
                else
                begin
                    pe_next    = EB'(slot_q_reg - VB'(2));
                    ent_raddr  = EB'(slot_q_reg - VB'(2));
                    state_next = S_PENT;
                end
            end

            S_PENT:
            begin
                if (ent_q_reg.hash == hsh_reg && ent_q_reg.x == kx_reg &&
                    ent_q_reg.y == ky_reg)
                begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = 9'(pe_reg);
                    state_next           = S_TML;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            S_DECIDE:
            begin
                state_next = S_TML;
                if (op_reg == OP_GET)
                begin
                    if (tbl_full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else if (need_mark && mcnt_reg >= MCB'(MARKS))
                    begin
                        res_next.status = ST_MARK_OVF;
                    end
                    else
                    begin
                        if (need_mark)
                        begin
                            mark_we    = 1'b1;
                            mark_waddr = MB'(mcnt_reg);
                            mark_wdata = '{level: level_reg, pos: alloc_reg};
                            mcnt_next  = mcnt_reg + 1'b1;
                            toplv_next = level_reg;
                        end
                        ent_we     = 1'b1;
                        ent_waddr  = EB'(alloc_reg);
                        ent_wdata  = '{hash: hsh_reg, x: kx_reg, y: ky_reg};
                        slot_we    = 1'b1;
                        slot_waddr = {bank_reg, spot_reg};
                        slot_wdata = VB'(alloc_reg) + VB'(2);
                        alloc_next = alloc_reg + 1'b1;
                        live_next  = live_reg + 1'b1;
                        if (reuse_reg && del_reg != '0)
                        begin
                            del_next = del_reg - 1'b1;
                        end
                        res_next.entry_index = 9'(alloc_reg);
                        res_next.found       = 1'b1;
                        res_next.created     = 1'b1;
                    end
                end
            end

            S_POPMARK:
            begin
                state_next = S_RMEND;
                if (mark_q_reg.pos <= alloc_reg)
                begin
                    res_next.removed_count = 10'(alloc_reg - mark_q_reg.pos);
                    alloc_next = mark_q_reg.pos;
                    rmend_next = alloc_reg;
                    rme_next   = mark_q_reg.pos;
                    if (mark_q_reg.pos < alloc_reg)
                    begin
                        ent_raddr  = EB'(mark_q_reg.pos);
                        state_next = S_RMENT;
                    end
                end
            end

            S_RMENT:
            begin
                j_next     = ent_q_reg.hash[SB-1:0];
                n_next     = '0;
                slot_raddr = {bank_reg, ent_q_reg.hash[SB-1:0]};
                state_next = S_RMSLOT;
            end

            S_RMSLOT:
            begin
                if (slot_q_reg == VB'(rme_reg) + VB'(2))
                begin
                    slot_we    = 1'b1;
                    slot_waddr = {bank_reg, j_reg};
                    slot_wdata = VB'(SLOT_DEAD);
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                    del_next = del_reg + 1'b1;
                    rm_step  = 1'b1;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            S_RMEND:
            begin
                if (LW'(del_reg) > LW'(cfg.cleanup_limit))
                begin
                    rebuild_next = 1'b1;
                    idx_next     = '0;
                    state_next   = S_CLEAR;
                end
                else
                begin
                    state_next = S_MARKDROP;
                end
            end

            S_RBSLOT:
            begin
                rbv_next = slot_q_reg;
                if (slot_q_reg >= VB'(2))
                begin
                    ent_raddr  = EB'(slot_q_reg - VB'(2));
                    state_next = S_RBENT;
                end
                else
                begin
                    rb_step = 1'b1;
                end
            end

            S_RBENT:
            begin
                j_next     = ent_q_reg.hash[SB-1:0];
                slot_raddr = {~bank_reg, ent_q_reg.hash[SB-1:0]};
                state_next = S_RBPROBE;
            end

            S_RBPROBE:
            begin
                if (slot_q_reg == VB'(SLOT_EMPTY))
                begin
                    slot_we    = 1'b1;
                    slot_waddr = {~bank_reg, j_reg};
                    slot_wdata = rbv_reg;
                    rb_step    = 1'b1;
                end
                else
                begin
                    j_next     = j_inc;
                    slot_raddr = {~bank_reg, j_inc};
                end
            end

            S_MARKDROP:
            begin
                mcnt_next = mtop;
                if (mtop != '0)
                begin
                    mark_raddr = MB'(mtop - 1'b1);
                    state_next = S_TML;
                    op_next    = OP_POP;
                    res_next.found = 1'b0;
                    toplv_next = toplv_reg;
                    rbv_next   = rbv_reg;
                    dseen_next = 1'b1;
                end
                else
                begin
                    toplv_next = '0;
                    level_next = level_reg - 1'b1;
                    dseen_next = 1'b0;
                    state_next = S_TML;
                end
            end

            // finish: for a pop with a lower mark, load its level first
            S_TML:
            begin
                if (op_reg == OP_POP && dseen_reg && res_reg.status == ST_OK &&
                    !res_reg.found)
                begin
                    toplv_next = mark_q_reg.level;
                    level_next = level_reg - 1'b1;
                    dseen_next = 1'b0;
                end
                else
                begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next slot of a linear probe
        if (adv)
        begin
            j_next = j_inc;
            n_next = n_inc;
            if (n_inc == (SB+1)'(SLOTS))
            begin
                if (state_reg == S_RMSLOT)
                begin
                    rm_step = 1'b1;
                end
                else
                begin
                    state_next = S_DECIDE;
                    if (dseen_next)
                    begin
                        spot_next  = dat_next;
                        reuse_next = 1'b1;
                    end
                    else
                    begin
                        nospot_next = 1'b1;
                    end
                end
            end
            else
            begin
                slot_raddr = {bank_reg, j_inc};
                state_next = (state_reg == S_RMSLOT) ? S_RMSLOT : S_PROBE;
            end
        end

        // advance to the next entry to delete
        if (rm_step)
        begin
            rme_next = e_inc;
            if (e_inc < rmend_reg)
            begin
                ent_raddr  = EB'(e_inc);
                state_next = S_RMENT;
            end
            else
            begin
                state_next = S_RMEND;
            end
        end

        // advance the rebuild scan; swap banks at its end
        if (rb_step)
        begin
            if (idx_reg == SB'(SLOTS - 1))
            begin
                bank_next    = ~bank_reg;
                del_next     = '0;
                rebuild_next = 1'b0;
                state_next   = S_MARKDROP;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                slot_raddr = {bank_reg, idx_reg + 1'b1};
                state_next = S_RBSLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            level_reg   <= '0;
            toplv_reg   <= '0;
            mcnt_reg    <= '0;
            alloc_reg   <= '0;
            live_reg    <= '0;
            del_reg     <= '0;
            bank_reg    <= 1'b0;
            rebuild_reg <= 1'b0;
            idx_reg     <= '0;
            dseen_reg   <= 1'b0;
            op_reg      <= OP_FIND;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            toplv_reg   <= toplv_next;
            mcnt_reg    <= mcnt_next;
            alloc_reg   <= alloc_next;
            live_reg    <= live_next;
            del_reg     <= del_next;
            bank_reg    <= bank_next;
            rebuild_reg <= rebuild_next;
            idx_reg     <= idx_next;
            dseen_reg   <= dseen_next;
            op_reg      <= op_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        hsh_reg    <= hsh_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        dat_reg    <= dat_next;
        pe_reg     <= pe_next;
        spot_reg   <= spot_next;
        reuse_reg  <= reuse_next;
        nospot_reg <= nospot_next;
        rme_reg    <= rme_next;
        rmend_reg  <= rmend_next;
        rbv_reg    <= rbv_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_q_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q_reg <= mark_mem[mark_raddr];
    end

endmodule

// ===== rtl/backtrackable_pair_hash_table.sv =====
// Top level of the backtrackable hash table keyed by a pair of 32-bit integers.
//
// Use: items go in through a queue-style port (push / full); an item is taken
// at a clock edge with push high and full low. Every item gives one result,
// offered on the result port while empty is low and taken on an edge with pop
// high. Operations: find, get-or-insert, push level, pop level.
// Flow: the front end mixes the key pair in a stalling pipeline; the back
// end then probes one slot at a time for find and get, reading and comparing
// the entry of each occupied slot; push only steps the level up; pop walks a
// probe per entry removed; a rebuild, when it runs, sweeps the spare slot bank
// empty and reinserts each live entry. The back end takes a new item only
// once done with the last, and its single slot memory read port sets the rate.
// Reset: all control state clears; the slot table is then swept empty, one
// slot a cycle over all SLOTS slots (1024 by default), with full held high.
// Configuration writes (cfg_valid / cfg_ready, always ready) are taken at any
// time and must only be issued while the block is idle.
// Stall: if results are not popped, the two-deep output queue fills, the back
// end holds, the middle queue and the mix pipeline fill and full rises.
module backtrackable_pair_hash_table #(
    parameter int SLOTS   = 1024,
    parameter int ENTRIES = 512,
    parameter int MARKS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bpht_pkg::in_item_t item,
    output logic               empty,
    input  logic               pop,
    output bpht_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [9:0]         cfg_data
);
    import bpht_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    fe_item_t fe_item, mq_item;
    logic     fe_push, fe_full, mq_empty, mq_pop;
    logic     out_push, out_full, init_busy;
    result_t  back_res;

    assign cfg_ready = 1'b1;

    // hold the configuration registers; write one per transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOAD_LIMIT:    cfg_next.load_limit    = cfg_data;
                CFG_CLEANUP_LIMIT: cfg_next.cleanup_limit = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{load_limit: 10'd716, cleanup_limit: 10'd204};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept and hash
    bpht_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .hold    (init_busy),
        .fe_item (fe_item),
        .fe_push (fe_push),
        .fe_full (fe_full)
    );

    // decoupling queue between front and back
    bpht_queue #(
        .WIDTH ($bits(fe_item_t)),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .din   (fe_item),
        .full  (fe_full),
        .pop   (mq_pop),
        .dout  (mq_item),
        .empty (mq_empty)
    );

    // back end: probe, insert, undo and rebuild
    bpht_back #(
        .SLOTS   (SLOTS),
        .ENTRIES (ENTRIES),
        .MARKS   (MARKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mq_item   (mq_item),
        .mq_empty  (mq_empty),
        .mq_pop    (mq_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_res   (back_res),
        .init_busy (init_busy)
    );

    // result queue: parts the back end from a stalled receiver
    bpht_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
